/* rtl/core/text_integer_scanner_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the text integer scanner
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_INTEGER_SCANNER_UNIT_MACROS_SVH
`define TEXT_INTEGER_SCANNER_UNIT_MACROS_SVH

// Clocked assertion with active-low reset disable
`define TISC_ASSERT_CLK(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) else $error(msg);

// Same, on the block clock and reset
`define TISC_ASSERT(lbl, prop, msg) \
	`TISC_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

/* rtl/core/tisc_pkg.sv */
// ----------------------------------------------------------------------------
// tisc_pkg
// Types, codes and digit decode for the text integer scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package tisc_pkg;

	// scan phases
	localparam logic [2:0] PH_WS     = 3'd0;
	localparam logic [2:0] PH_START  = 3'd1;
	localparam logic [2:0] PH_ZERO   = 3'd2;
	localparam logic [2:0] PH_PREFIX = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	// digit bases
	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_HEX = 2'd1;
	localparam logic [1:0] BASE_OCT = 2'd2;

	// conversion modes
	localparam logic [2:0] MODE_DEC  = 3'd0;
	localparam logic [2:0] MODE_AUTO = 3'd1;
	localparam logic [2:0] MODE_UNS  = 3'd2;
	localparam logic [2:0] MODE_HEX  = 3'd3;
	localparam logic [2:0] MODE_OCT  = 3'd4;

	// store sizes
	localparam logic [1:0] SIZE_8  = 2'd0;
	localparam logic [1:0] SIZE_16 = 2'd1;
	localparam logic [1:0] SIZE_32 = 2'd2;
	localparam logic [1:0] SIZE_64 = 2'd3;

	// config register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE = 2'd1;

	localparam int unsigned CNT_OUT_W = 13;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CASE_BIT = 8'h20;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} dig_t;

	function automatic dig_t digit_of(input logic [7:0] c, input logic [1:0] base);
		dig_t       d;
		logic [7:0] low;
		low   = c | CASE_BIT;
		d.ok  = 1'b0;
		d.val = c[3:0];
		if (base == BASE_OCT) begin
			d.ok = (c >= CH_ZERO) && (c <= CH_SEVEN);
		end else if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
			d.ok = 1'b1;
		end else if ((base == BASE_HEX) && (low >= CH_LA) && (low <= CH_LF)) begin
			d.ok  = 1'b1;
			d.val = low[3:0] + 4'd9;
		end
		return d;
	endfunction

	function automatic logic [1:0] mode_base(input logic [2:0] mode);
		logic [1:0] b;
		case (mode)
			MODE_HEX: b = BASE_HEX;
			MODE_OCT: b = BASE_OCT;
			default:  b = BASE_DEC;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/text_integer_scanner_unit.sv */
// A beat passes the input register and then the output register on its way to the master side.
// Throughput: one character per cycle; the input register stalls only while a result
// waits on the master side and the staged character would produce another one.
// The per-character update is one shift-add into the 64-bit accumulator.
// Reset (arst_n low) clears the scan state, the input and output valid flags and the
// config registers (mode decimal, store size 32 bits) at once.
// ----------------------------------------------------------------------------
// text_integer_scanner_unit
// Streams characters and returns one scanned integer per number or text run.
// ----------------------------------------------------------------------------
`default_nettype none

module text_integer_scanner_unit
	import tisc_pkg::*;
#(
	parameter int unsigned MAX_CHARS = 4096
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// character stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,   // [7:0] ch
	input  wire logic                 s_tlast,   // last
	// results
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [79:0]               m_tdata,   // [63:0] value, [76:64] consumed, [79:77] 0
	output logic                      m_tuser,   // [0] ok
	// config writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [2:0]           cfg_data
);

	localparam int unsigned CNT_W = $clog2(MAX_CHARS + 1);

	// config registers
	logic [2:0] mode_q;
	logic [1:0] size_q;

	// input stage
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;

	// scan state
	logic [2:0]       phase_q;
	logic             neg_q;
	logic [1:0]       base_q;
	logic [63:0]      acc_q;
	logic             seen_q;
	logic [CNT_W-1:0] cnt_q;

	// output register
	logic             out_valid_q;
	logic [63:0]      out_acc_q;
	logic             out_neg_q;
	logic             out_seen_q;
	logic [1:0]       out_size_q;
	logic [CNT_W-1:0] out_cnt_q;

	// next-state logic
	logic             take;
	logic             produce;
	logic             adv;
	logic             out_free;
	logic [2:0]       nx_phase;
	logic             nx_neg;
	logic [1:0]       nx_base;
	logic [63:0]      nx_acc;
	logic             nx_seen;
	logic [CNT_W-1:0] nx_cnt;
	logic [63:0]      acc_step;
	logic [63:0]      sv;
	logic [63:0]      value;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DEC;
			size_q <= SIZE_32;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE: mode_q <= cfg_data;
				REG_SIZE: size_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign adv      = valid_s1 && (!produce || out_free);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// next accumulator in digit phase
	always_comb begin
		dig_t d;
		d = digit_of(ch_s1, base_q);
		case (base_q)
			BASE_HEX: acc_step = {acc_q[59:0], 4'd0};
			BASE_OCT: acc_step = {acc_q[60:0], 3'd0};
			default:  acc_step = {acc_q[60:0], 3'd0} + {acc_q[62:0], 1'b0};
		endcase
		acc_step = acc_step + {60'd0, d.val};
	end

	always_comb begin
		dig_t       d_mode;
		dig_t       d_hex;
		dig_t       d_oct;
		dig_t       d_dec;
		dig_t       d_act;
		logic [2:0] ph;
		logic       is_ws;
		d_mode   = digit_of(ch_s1, mode_base(mode_q));
		d_hex    = digit_of(ch_s1, BASE_HEX);
		d_oct    = digit_of(ch_s1, BASE_OCT);
		d_dec    = digit_of(ch_s1, BASE_DEC);
		d_act    = digit_of(ch_s1, base_q);
		is_ws    = (ch_s1 == CH_SPACE) || ((ch_s1 >= CH_TAB) && (ch_s1 <= CH_CR));
		nx_phase = phase_q;
		nx_neg   = neg_q;
		nx_base  = base_q;
		nx_acc   = acc_q;
		nx_seen  = seen_q;
		take     = 1'b0;
		ph       = phase_q;

		// whitespace / sign handled before the main decode
		if (phase_q == PH_WS) begin
			if (is_ws) begin
				take = 1'b1;
			end else begin
				nx_phase = PH_START;
				if (ch_s1 == CH_MINUS) begin
					nx_neg = 1'b1;
					take   = 1'b1;
				end else begin
					ph = PH_START;
				end
			end
		end

		unique case (ph)
			PH_START: begin
				if (((mode_q == MODE_AUTO) || (mode_q == MODE_HEX)) && (ch_s1 == CH_ZERO)) begin
					nx_acc   = 64'd0;
					nx_seen  = 1'b1;
					nx_phase = PH_ZERO;
					take     = 1'b1;
				end else if (d_mode.ok) begin
					nx_base  = mode_base(mode_q);
					nx_acc   = {60'd0, d_mode.val};
					nx_seen  = 1'b1;
					nx_phase = PH_DIGITS;
					take     = 1'b1;
				end
			end
			PH_ZERO: begin
				if ((ch_s1 | CASE_BIT) == CH_LX) begin
					nx_seen  = 1'b0;
					nx_base  = BASE_HEX;
					nx_phase = PH_PREFIX;
					take     = 1'b1;
				end else if (mode_q == MODE_HEX) begin
					if (d_hex.ok) begin
						nx_base  = BASE_HEX;
						nx_acc   = {60'd0, d_hex.val};
						nx_seen  = 1'b1;
						nx_phase = PH_DIGITS;
						take     = 1'b1;
					end
				end else if (d_oct.ok) begin
					nx_base  = BASE_OCT;
					nx_acc   = {60'd0, d_oct.val};
					nx_seen  = 1'b1;
					nx_phase = PH_DIGITS;
					take     = 1'b1;
				end else if (d_dec.ok) begin
					// "0" then 8 or 9 goes on in decimal
					nx_base  = BASE_DEC;
					nx_acc   = {60'd0, d_dec.val};
					nx_seen  = 1'b1;
					nx_phase = PH_DIGITS;
					take     = 1'b1;
				end
			end
			PH_PREFIX: begin
				if (d_hex.ok) begin
					nx_base  = BASE_HEX;
					nx_acc   = {60'd0, d_hex.val};
					nx_seen  = 1'b1;
					nx_phase = PH_DIGITS;
					take     = 1'b1;
				end
			end
			PH_DIGITS: begin
				if (d_act.ok) begin
					nx_acc = acc_step;
					take   = 1'b1;
				end
			end
			default: ;
		endcase

		produce = (phase_q != PH_DONE) && (!take || last_s1);
		nx_cnt  = (take && (cnt_q < CNT_W'(MAX_CHARS))) ? cnt_q + 1'b1 : cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WS;
			neg_q   <= 1'b0;
			base_q  <= BASE_DEC;
			acc_q   <= 64'd0;
			seen_q  <= 1'b0;
			cnt_q   <= '0;
		end else if (adv) begin
			if (last_s1) begin
				phase_q <= PH_WS;
				neg_q   <= 1'b0;
				base_q  <= BASE_DEC;
				acc_q   <= 64'd0;
				seen_q  <= 1'b0;
				cnt_q   <= '0;
			end else if (phase_q != PH_DONE) begin
				phase_q <= produce ? PH_DONE : nx_phase;
				neg_q   <= nx_neg;
				base_q  <= nx_base;
				acc_q   <= nx_acc;
				seen_q  <= nx_seen;
				cnt_q   <= nx_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && produce) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && produce) begin
			out_acc_q  <= nx_acc;
			out_neg_q  <= nx_neg;
			out_seen_q <= nx_seen;
			out_size_q <= size_q;
			out_cnt_q  <= nx_cnt;
		end
	end

	// sign and truncation on the registered accumulator
	always_comb begin
		sv = out_neg_q ? (64'd0 - out_acc_q) : out_acc_q;
		case (out_size_q)
			SIZE_8:  value = {56'd0, sv[7:0]};
			SIZE_16: value = {48'd0, sv[15:0]};
			SIZE_32: value = {32'd0, sv[31:0]};
			default: value = sv;
		endcase
		if (!out_seen_q) begin
			value = 64'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_seen_q;
	assign m_tdata  = {3'd0, CNT_OUT_W'(out_cnt_q), value};

endmodule

`default_nettype wire

/* rtl/core/tisc_checker.sv */
// ----------------------------------------------------------------------------
// tisc_checker
// Port-level checks on the text integer scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_integer_scanner_unit_macros.svh"

module tisc_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [79:0]          m_tdata,
	input wire logic                 m_tuser
);

	// a stalled result beat stays offered
	`TISC_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped while stalled")

	// no converted digit means a zero value
	`TISC_ASSERT(a_nodigit_zero, m_tvalid && !m_tuser |-> m_tdata[63:0] == 64'd0, "value set without digits")

	// pad bits above the count stay zero
	`TISC_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[79:77] == 3'd0, "tdata pad bits nonzero")

	// a fresh result needs an input beat accepted before it
	`TISC_ASSERT(a_cause, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2), "result without input beat")

endmodule

bind text_integer_scanner_unit tisc_checker u_tisc_checker (.*);

`default_nettype wire

/* tb/sv/text_integer_scanner_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_integer_scanner_unit_test
// Drives character streams into the integer scanner and checks every result
// beat against a cycle-free model of the scan kept in the bench or against
// a value set in the short directed table, which comes first; then random
// texts under changing modes and store sizes, with random gaps on the
// character side and random stalls on the result side, then a long space run.
// ----------------------------------------------------------------------------

module text_integer_scanner_unit_test;
	import tisc_pkg::*;

	localparam int unsigned SCAN_MAX_CHARS = 4096;
	localparam int unsigned RANDOM_CHARS   = 1650;
	localparam int unsigned LONG_SPACE_RUN = 24;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam logic [2:0]  MODE_SPARE     = 3'd7;   // undefined mode, scans as decimal
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;

	typedef struct packed {
		logic [63:0] value;
		logic        ok;
		logic [12:0] consumed;
	} scan_result_t;

	typedef enum logic {ROW_CHAR, ROW_REG} row_kind_e;

	typedef struct packed {
		row_kind_e           kind;
		logic [7:0]          ch;
		logic                last;
		logic [CFG_IDX_W-1:0] idx;
		logic [2:0]          data;
		logic                typed;
		scan_result_t        want;
	} stim_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = 8'd0;
	logic                 s_tlast   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [79:0]          m_tdata;   // [63:0] value, [76:64] consumed, [79:77] 0
	logic                 m_tuser;   // [0] ok
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [2:0]           cfg_data  = 3'd0;

	text_integer_scanner_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// scan model state
	logic [2:0]  cur_mode;
	logic [1:0]  cur_size;
	logic [2:0]  scan_phase;
	logic        scan_neg;
	logic [1:0]  scan_base;
	logic [63:0] scan_acc;
	logic        scan_seen;
	int unsigned scan_count;

	scan_result_t expected_q[$];
	stim_row_t    plan[$];
	logic [7:0]   text_buf[$];
	logic [7:0]   carry_buf[$];
	string        digit_set = "0123456789abcdefABCDEF";

	int  mismatches  = 0;
	int  chars_fed   = 0;
	int  ready_hold  = 0;
	bit  quiet_phase = 1'b0;

	function automatic void clear_scan();
		scan_phase = PH_WS;
		scan_neg   = 1'b0;
		scan_base  = BASE_DEC;
		scan_acc   = 64'd0;
		scan_seen  = 1'b0;
		scan_count = 0;
	endfunction

	function automatic bit char_digit(input logic [7:0] c, input logic [1:0] b,
			output logic [3:0] d);
		logic [7:0] lc;
		lc = c | 8'h20;
		d  = 4'd0;
		if (b == BASE_OCT) begin
			if (c >= "0" && c <= "7") begin
				d = 4'(c - "0");
				return 1'b1;
			end
			return 1'b0;
		end
		if (c >= "0" && c <= "9") begin
			d = 4'(c - "0");
			return 1'b1;
		end
		if (b == BASE_HEX && lc >= "a" && lc <= "f") begin
			d = 4'(lc - "a" + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void start_number(input logic [1:0] b, input logic [3:0] d);
		scan_base  = b;
		scan_acc   = {60'd0, d};
		scan_seen  = 1'b1;
		scan_phase = PH_DIGITS;
	endfunction

	// 1 when the character is consumed by the scan
	function automatic bit take_char(input logic [7:0] c);
		logic [3:0] d;
		logic [1:0] mb;
		logic [63:0] factor;
		mb = (cur_mode == MODE_HEX) ? BASE_HEX : (cur_mode == MODE_OCT) ? BASE_OCT : BASE_DEC;
		if (scan_phase == PH_WS) begin
			if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
				return 1'b1;
			scan_phase = PH_START;
			if (c == CH_MINUS) begin
				scan_neg = 1'b1;
				return 1'b1;
			end
		end
		case (scan_phase)
			PH_START: begin
				if ((cur_mode == MODE_AUTO || cur_mode == MODE_HEX) && c == CH_ZERO) begin
					scan_acc   = 64'd0;
					scan_seen  = 1'b1;
					scan_phase = PH_ZERO;
					return 1'b1;
				end
				if (!char_digit(c, mb, d))
					return 1'b0;
				start_number(mb, d);
				return 1'b1;
			end
			PH_ZERO: begin
				if ((c | CASE_BIT) == CH_LX) begin
					scan_seen  = 1'b0;
					scan_base  = BASE_HEX;
					scan_phase = PH_PREFIX;
					return 1'b1;
				end
				if (cur_mode == MODE_HEX) begin
					if (!char_digit(c, BASE_HEX, d))
						return 1'b0;
					start_number(BASE_HEX, d);
					return 1'b1;
				end
				if (char_digit(c, BASE_OCT, d)) begin
					start_number(BASE_OCT, d);
					return 1'b1;
				end
				if (char_digit(c, BASE_DEC, d)) begin
					start_number(BASE_DEC, d);
					return 1'b1;
				end
				return 1'b0;
			end
			PH_PREFIX: begin
				if (!char_digit(c, BASE_HEX, d))
					return 1'b0;
				start_number(BASE_HEX, d);
				return 1'b1;
			end
			PH_DIGITS: begin
				if (!char_digit(c, scan_base, d))
					return 1'b0;
				factor = (scan_base == BASE_HEX) ? 64'd16 : (scan_base == BASE_OCT) ? 64'd8 : 64'd10;
				scan_acc = scan_acc * factor + {60'd0, d};
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// advances the model by one character; 1 when it yields a result
	function automatic bit scan_step(input logic [7:0] c, input logic l,
			output scan_result_t r);
		logic [63:0] v;
		r = '0;
		if (scan_phase == PH_DONE) begin
			if (l)
				clear_scan();
			return 1'b0;
		end
		if (take_char(c)) begin
			if (scan_count < SCAN_MAX_CHARS)
				scan_count++;
			if (!l)
				return 1'b0;
		end
		v = 64'd0;
		if (scan_seen) begin
			v = scan_neg ? (64'd0 - scan_acc) : scan_acc;
			case (cur_size)
				SIZE_8:  v = {56'd0, v[7:0]};
				SIZE_16: v = {48'd0, v[15:0]};
				SIZE_32: v = {32'd0, v[31:0]};
				default: ;
			endcase
		end
		r.value    = v;
		r.ok       = scan_seen;
		r.consumed = 13'(scan_count);
		if (l)
			clear_scan();
		else
			scan_phase = PH_DONE;
		return 1'b1;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [2:0] data);
		if (idx == REG_MODE)
			cur_mode = data;
		else if (idx == REG_SIZE)
			cur_size = data[1:0];
	endfunction

	// mostly short idle stretches, now and then a long one
	function automatic int idle_len();
		int r;
		if (quiet_phase)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// called at a falling edge, returns at a falling edge with tvalid still up
	task automatic send_char(input logic [7:0] c, input logic l, input logic typed,
			input scan_result_t want);
		int gap;
		scan_result_t got;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= l;
		do @(posedge clk); while (!s_tready);
		chars_fed++;
		if (scan_step(c, l, got) && !typed)
			expected_q.push_back(got);
		if (typed)
			expected_q.push_back(want);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [2:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// lets the block drain before a register write
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic add_char(input logic [7:0] c, input logic l, input logic typed,
			input logic [63:0] v, input logic ok, input logic [12:0] cnt);
		stim_row_t r;
		r.kind           = ROW_CHAR;
		r.ch             = c;
		r.last           = l;
		r.idx            = REG_MODE;
		r.data           = 3'd0;
		r.typed          = typed;
		r.want.value     = v;
		r.want.ok        = ok;
		r.want.consumed  = cnt;
		plan.push_back(r);
	endtask

	task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [2:0] data);
		stim_row_t r;
		r      = '0;
		r.kind = ROW_REG;
		r.idx  = idx;
		r.data = data;
		plan.push_back(r);
	endtask

	task automatic build_plan();
		// reset settings: decimal, 32-bit store
		add_char(CH_SPACE, 1'b0, 1'b0, 64'd0, 1'b0, 13'd0);
		add_char(CH_TAB,   1'b0, 1'b0, 64'd0, 1'b0, 13'd0);
		add_char(CH_CR,    1'b0, 1'b0, 64'd0, 1'b0, 13'd0);
		add_char(CH_MINUS, 1'b0, 1'b0, 64'd0, 1'b0, 13'd0);
		add_char("1",      1'b0, 1'b0, 64'd0, 1'b0, 13'd0);
		add_char("z",      1'b0, 1'b1, 64'h0000_0000_FFFF_FFFF, 1'b1, 13'd5);
		add_char("q",      1'b1, 1'b0, 64'd0, 1'b0, 13'd0);   // last after result
		add_reg(REG_MODE, MODE_HEX);
		add_reg(REG_SIZE, SIZE_64);
		add_char("0",      1'b0, 1'b0, 64'd0, 1'b0, 13'd0);
		add_char("X",      1'b0, 1'b0, 64'd0, 1'b0, 13'd0);
		add_char("f",      1'b0, 1'b0, 64'd0, 1'b0, 13'd0);
		add_char("F",      1'b1, 1'b1, 64'hFF, 1'b1, 13'd4);
		// prefix with no hex digit behind it
		add_char("0",      1'b0, 1'b0, 64'd0, 1'b0, 13'd0);
		add_char("x",      1'b0, 1'b0, 64'd0, 1'b0, 13'd0);
		add_char("g",      1'b0, 1'b1, 64'd0, 1'b0, 13'd2);
		add_char(8'h00,    1'b1, 1'b0, 64'd0, 1'b0, 13'd0);
		add_reg(REG_MODE, MODE_AUTO);
		add_reg(REG_SIZE, SIZE_8);
		add_char("0",      1'b0, 1'b0, 64'd0, 1'b0, 13'd0);
		add_char("8",      1'b0, 1'b0, 64'd0, 1'b0, 13'd0);   // continues in decimal
		add_char("+",      1'b1, 1'b0, 64'd0, 1'b0, 13'd0);
		add_char("0",      1'b0, 1'b0, 64'd0, 1'b0, 13'd0);
		add_char(8'h00,    1'b1, 1'b1, 64'd0, 1'b1, 13'd1);
		add_reg(REG_MODE, MODE_SPARE);
		add_reg(REG_SIZE, 3'd5);                                // upper bit dropped: 16-bit
		add_reg(REG_UNUSED, 3'd3);
		add_char("+",      1'b1, 1'b1, 64'd0, 1'b0, 13'd0);
		add_char(CH_MINUS, 1'b0, 1'b0, 64'd0, 1'b0, 13'd0);
		add_char(8'hFF,    1'b1, 1'b1, 64'd0, 1'b0, 13'd1);
		add_reg(REG_MODE, MODE_OCT);
		add_reg(REG_SIZE, 3'd3);
		add_char("7",      1'b0, 1'b0, 64'd0, 1'b0, 13'd0);
		add_char("8",      1'b1, 1'b0, 64'd0, 1'b0, 13'd0);
	endtask

	function automatic logic [7:0] pick_space();
		if ($urandom_range(0, 5) == 0)
			return CH_SPACE;
		return 8'($urandom_range(9, 13));
	endfunction

	// one random text, mostly well formed: space, sign, prefix, digits, tail
	task automatic build_text();
		int n;
		text_buf.delete();
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 8);
			repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
			return;
		end
		n = $urandom_range(0, 3);
		repeat (n) text_buf.push_back(pick_space());
		if ($urandom_range(0, 3) == 0)
			text_buf.push_back(CH_MINUS);
		if ($urandom_range(0, 11) == 0)
			text_buf.push_back("+");
		case ($urandom_range(0, 3))
			0: text_buf.push_back(CH_ZERO);
			1: begin
				text_buf.push_back(CH_ZERO);
				text_buf.push_back($urandom_range(0, 1) ? "x" : "X");
			end
			default: ;
		endcase
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 26) : $urandom_range(0, 6);
		repeat (n) begin
			if ($urandom_range(0, 9) == 0)
				text_buf.push_back(8'($urandom_range(0, 255)));
			else
				text_buf.push_back(digit_set[$urandom_range(0, digit_set.len() - 1)]);
		end
		if ($urandom_range(0, 2) != 0)
			text_buf.push_back(8'($urandom_range(0, 255)));
		n = $urandom_range(0, 2);
		repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
		if (text_buf.size() == 0)
			text_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	// result side stalls
	always @(negedge clk) begin
		if (ready_hold == 0 && $urandom_range(0, 3) == 0)
			ready_hold = idle_len();
		if (ready_hold > 0) begin
			ready_hold--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: result beat with nothing expected, value %h ok %b consumed %0d",
					$time, m_tdata[63:0], m_tuser, m_tdata[76:64]);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				if (m_tdata[63:0] !== want.value)
					report("value", want.value, m_tdata[63:0]);
				if (m_tuser !== want.ok)
					report("ok", 64'(want.ok), 64'(m_tuser));
				if (m_tdata[76:64] !== want.consumed)
					report("consumed", 64'(want.consumed), 64'(m_tdata[76:64]));
			end
		end
	end

	initial begin
		#40_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int i;
		int k;
		int p;
		int t;
		int texts;
		scan_result_t none;
		none     = '0;
		cur_mode = MODE_DEC;
		cur_size = SIZE_32;
		clear_scan();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		build_plan();
		for (i = 0; i < plan.size(); i++) begin
			if (plan[i].kind == ROW_REG) begin
				settle();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_char(plan[i].ch, plan[i].last, plan[i].typed, plan[i].want);
			end
		end

		chars_fed = 0;
		p = 0;
		while (chars_fed < RANDOM_CHARS) begin
			settle();
			quiet_phase = ($urandom_range(0, 4) == 0);
			// first phases walk every mode and every store size code
			if (p < 8) begin
				write_reg(REG_MODE, 3'(p));
				write_reg(REG_SIZE, 3'(p));
			end else begin
				write_reg(REG_MODE, 3'($urandom_range(0, 7)));
				write_reg(REG_SIZE, 3'($urandom_range(0, 7)));
			end
			if ($urandom_range(0, 3) == 0)
				write_reg(2'($urandom_range(2, 3)), 3'($urandom_range(0, 7)));
			p++;
			// rest of a text cut off by the last phase change
			for (i = 0; i < carry_buf.size(); i++)
				send_char(carry_buf[i], i == carry_buf.size() - 1, 1'b0, none);
			carry_buf.delete();
			texts = $urandom_range(3, 12);
			for (t = 0; t < texts; t++) begin
				build_text();
				k = text_buf.size();
				if (t == texts - 1 && k > 1 && $urandom_range(0, 5) == 0) begin
					k = $urandom_range(1, text_buf.size() - 1);
					for (i = k; i < text_buf.size(); i++)
						carry_buf.push_back(text_buf[i]);
				end
				for (i = 0; i < k; i++)
					send_char(text_buf[i], i == text_buf.size() - 1, 1'b0, none);
			end
		end
		for (i = 0; i < carry_buf.size(); i++)
			send_char(carry_buf[i], i == carry_buf.size() - 1, 1'b0, none);

		// long leading space run ahead of a number
		settle();
		quiet_phase = 1'b0;
		write_reg(REG_MODE, MODE_DEC);
		write_reg(REG_SIZE, SIZE_64);
		repeat (LONG_SPACE_RUN) send_char(pick_space(), 1'b0, 1'b0, none);
		send_char("1", 1'b0, 1'b0, none);
		send_char("2", 1'b1, 1'b0, none);

		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/tisc_pkg.sv
rtl/core/text_integer_scanner_unit.sv
rtl/core/tisc_checker.sv
tb/sv/text_integer_scanner_unit_test.sv
